// ----- sv/trws_pkg.sv -----
// ----------------------------------------------------------------------------
// trws_pkg
// Shared types and constants for the tank refill / watering sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package trws_pkg;

  // Field widths
  localparam int unsigned LEVEL_W = 2;
  localparam int unsigned SECS_W  = 8;
  localparam int unsigned DRAIN_W = 6;
  localparam int unsigned ALERT_W = 4;
  localparam int unsigned TICK_W  = 6;
  localparam int unsigned FRAME_W = 3;
  localparam int unsigned MSG_W   = 4;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned CDAT_W  = 8;

  // Default for the top-level parameter
  localparam int unsigned TRWS_TICKS_PER_SECOND = 2;

  // Register reset values
  localparam logic [SECS_W-1:0]  WATER_SECS_RST = 8'd30;
  localparam logic [DRAIN_W-1:0] DRAIN_TICKS_RST = 6'd10;
  localparam logic [ALERT_W-1:0] ALERT_TICKS_RST = 4'd4;

  // Animation wraps after this frame
  localparam logic [FRAME_W-1:0] FRAME_LAST = 3'd6;

  // Tank level codes
  localparam logic [LEVEL_W-1:0] LVL_EMPTY   = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_PARTIAL = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_FULL    = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_BAD     = 2'd3;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_WATERING_SECONDS = 2'd0,
    CFG_DRAIN_TICKS      = 2'd1,
    CFG_ALERT_TICKS      = 2'd2
  } cfg_idx_t;

  // Display message codes
  typedef enum logic [MSG_W-1:0] {
    MSG_IDLE          = 4'd0,
    MSG_BOTH_EMPTY    = 4'd1,
    MSG_BOTH_REFILL   = 4'd2,
    MSG_REFILLING     = 4'd3,
    MSG_OVF_ALERT     = 4'd4,
    MSG_OVF_CLEARED   = 4'd5,
    MSG_RES_EMPTY     = 4'd6,
    MSG_MAIN_FULL     = 4'd7,
    MSG_WATER_START   = 4'd8,
    MSG_WATER_COUNT   = 4'd9,
    MSG_MAIN_EMPTY    = 4'd10,
    MSG_WATER_DONE    = 4'd11,
    MSG_RES_REFILL    = 4'd12,
    MSG_THANKS        = 4'd13
  } msg_t;

  // Sequencer modes, one-hot
  typedef enum logic [9:0] {
    M_IDLE     = 10'b00_0000_0001,
    M_RETRY    = 10'b00_0000_0010,
    M_REFILL   = 10'b00_0000_0100,
    M_DRAIN    = 10'b00_0000_1000,
    M_HOLD     = 10'b00_0001_0000,
    M_WSTART   = 10'b00_0010_0000,
    M_WATER    = 10'b00_0100_0000,
    M_COMPLETE = 10'b00_1000_0000,
    M_ALERT    = 10'b01_0000_0000,
    M_THANKS   = 10'b10_0000_0000
  } mode_t;

  // One tick word
  typedef struct packed {
    logic               start_request;
    logic [LEVEL_W-1:0] main_level;
    logic [LEVEL_W-1:0] reserve_level;
    logic               overflow_seen;
  } item_t;

  // One result word
  typedef struct packed {
    logic               refill_pump_on;
    logic               main_pump_on;
    logic [MSG_W-1:0]   message_code;
    logic [SECS_W-1:0]  seconds_left;
    logic [FRAME_W-1:0] anim_frame;
    logic               cycle_done;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/trws_if.sv -----
// ----------------------------------------------------------------------------
// trws_if
// Valid/ready channel interfaces: tick input, result output, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface trws_in_if
  import trws_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               start_request;
  logic [LEVEL_W-1:0] main_level;
  logic [LEVEL_W-1:0] reserve_level;
  logic               overflow_seen;

  modport source (output valid, start_request, main_level, reserve_level,
                  overflow_seen, input ready);
  modport sink   (input valid, start_request, main_level, reserve_level,
                  overflow_seen, output ready);
endinterface

interface trws_out_if
  import trws_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               refill_pump_on;
  logic               main_pump_on;
  logic [MSG_W-1:0]   message_code;
  logic [SECS_W-1:0]  seconds_left;
  logic [FRAME_W-1:0] anim_frame;
  logic               cycle_done;

  modport source (output valid, refill_pump_on, main_pump_on, message_code,
                  seconds_left, anim_frame, cycle_done, input ready);
  modport sink   (input valid, refill_pump_on, main_pump_on, message_code,
                  seconds_left, anim_frame, cycle_done, output ready);
endinterface

interface trws_cfg_if
  import trws_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/trws_in_reg.sv -----
// ----------------------------------------------------------------------------
// trws_in_reg
// Input register: captures one tick word, frees when the sequencer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module trws_in_reg
  import trws_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  trws_in_if.sink    in_ch,
  input  wire logic  take,
  output logic       valid_r,
  output item_t      item_r
);

  logic valid_nxt;

  // accept when empty or when the held word leaves this cycle
  assign in_ch.ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.valid && in_ch.ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.start_request <= in_ch.start_request;
      item_r.main_level    <= in_ch.main_level;
      item_r.reserve_level <= in_ch.reserve_level;
      item_r.overflow_seen <= in_ch.overflow_seen;
    end
  end

endmodule

`default_nettype wire

// ----- sv/trws_fsm.sv -----
// ----------------------------------------------------------------------------
// trws_fsm
// Config registers, sequencer state and the per-tick next-state/output logic.
// ----------------------------------------------------------------------------
`default_nettype none

module trws_fsm
  import trws_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = TRWS_TICKS_PER_SECOND
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  trws_cfg_if.sink   cfg_ch,
  input  wire logic  step,
  input  wire item_t item,
  output result_t    res
);

  localparam logic [TICK_W-1:0] TPS = TICK_W'(TICKS_PER_SECOND);

  // config registers
  logic [SECS_W-1:0]  water_secs_r;
  logic [DRAIN_W-1:0] drain_ticks_r;
  logic [ALERT_W-1:0] alert_ticks_r;

  // sequencer state
  mode_t              mode_r, mode_nxt;
  logic [SECS_W-1:0]  rem_r, rem_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;
  logic               tog_r, tog_nxt;
  logic               refill_need_r, refill_need_nxt;

  logic [LEVEL_W-1:0] ml, rl;
  logic [ALERT_W-1:0] period;
  logic [TICK_W-1:0]  tick_inc;
  logic [SECS_W-1:0]  rem_dec;
  logic               do_entry, do_refill, do_wstart;
  logic               alert_tog;

  // config port always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      water_secs_r  <= WATER_SECS_RST;
      drain_ticks_r <= DRAIN_TICKS_RST;
      alert_ticks_r <= ALERT_TICKS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_WATERING_SECONDS: water_secs_r  <= cfg_ch.data;
        CFG_DRAIN_TICKS:      drain_ticks_r <= cfg_ch.data[DRAIN_W-1:0];
        CFG_ALERT_TICKS:      alert_ticks_r <= cfg_ch.data[ALERT_W-1:0];
        default: ;
      endcase
    end
  end

  // level code three reads as partial
  assign ml = (item.main_level == LVL_BAD) ? LVL_PARTIAL : item.main_level;
  assign rl = (item.reserve_level == LVL_BAD) ? LVL_PARTIAL : item.reserve_level;

  assign period   = (alert_ticks_r == '0) ? ALERT_W'(1) : alert_ticks_r;
  assign tick_inc = tick_r + TICK_W'(1);
  assign rem_dec  = rem_r - SECS_W'(1);
  assign alert_tog = (tick_r == '0) ? ~tog_r : tog_r;

  // next state and result for one tick
  always_comb begin
    mode_nxt        = mode_r;
    rem_nxt         = rem_r;
    tick_nxt        = tick_r;
    frame_nxt       = frame_r;
    tog_nxt         = tog_r;
    refill_need_nxt = refill_need_r;
    res             = '0;
    res.message_code = MSG_IDLE;
    do_entry        = 1'b0;
    do_refill       = 1'b0;
    do_wstart       = 1'b0;

    unique case (mode_r)
      M_IDLE: begin
        if (item.start_request) begin
          rem_nxt         = water_secs_r;
          refill_need_nxt = 1'b0;
          do_entry        = 1'b1;
        end
      end
      M_RETRY:  do_entry  = 1'b1;
      M_REFILL: do_refill = 1'b1;
      M_DRAIN: begin
        res.main_pump_on = 1'b1;
        res.message_code = MSG_REFILLING;
        tick_nxt         = tick_inc;
        if (tick_inc >= TICK_W'(drain_ticks_r)) begin
          mode_nxt = M_HOLD;
        end
      end
      M_HOLD: begin
        if (item.overflow_seen) begin
          res.message_code = MSG_OVF_ALERT;
        end else begin
          res.message_code = MSG_OVF_CLEARED;
          mode_nxt         = M_REFILL;
        end
        tick_nxt = '0;
      end
      M_WSTART: do_wstart = 1'b1;
      M_WATER: begin
        if (tick_r == '0 && ml == LVL_EMPTY) begin
          res.message_code = MSG_MAIN_EMPTY;
          mode_nxt         = M_RETRY;
        end else begin
          res.main_pump_on = 1'b1;
          res.message_code = MSG_WATER_COUNT;
          res.seconds_left = rem_r;
          res.anim_frame   = frame_r;
          tick_nxt         = tick_inc;
          // one second elapsed
          if (tick_inc >= TPS) begin
            tick_nxt  = '0;
            rem_nxt   = rem_dec;
            frame_nxt = (frame_r == FRAME_LAST) ? '0 : frame_r + FRAME_W'(1);
            if (rem_dec == '0) begin
              mode_nxt = M_COMPLETE;
            end
          end
        end
      end
      M_COMPLETE: begin
        res.message_code = MSG_WATER_DONE;
        tick_nxt         = '0;
        if (rl == LVL_EMPTY) begin
          refill_need_nxt = 1'b1;
          mode_nxt        = M_ALERT;
        end else begin
          res.cycle_done = 1'b1;
          mode_nxt       = M_IDLE;
        end
      end
      M_ALERT: begin
        tog_nxt          = alert_tog;
        res.message_code = alert_tog ? MSG_RES_EMPTY : MSG_RES_REFILL;
        tick_nxt         = tick_inc;
        if (tick_inc >= TICK_W'(period)) begin
          tick_nxt = '0;
          if (rl != LVL_EMPTY) begin
            if (refill_need_r) begin
              mode_nxt = M_THANKS;
            end else begin
              res.cycle_done = 1'b1;
              mode_nxt       = M_IDLE;
            end
          end
        end
      end
      M_THANKS: begin
        res.message_code = MSG_THANKS;
        tick_nxt         = tick_inc;
        if (tick_inc >= TICK_W'(period)) begin
          tick_nxt        = '0;
          refill_need_nxt = 1'b0;
          res.cycle_done  = 1'b1;
          mode_nxt        = M_IDLE;
        end
      end
      default: begin
        mode_nxt = M_IDLE;
        tick_nxt = '0;
      end
    endcase

    // cycle entry: look at both tanks
    if (do_entry) begin
      if (ml == LVL_EMPTY && rl == LVL_EMPTY) begin
        tog_nxt          = ~tog_r;
        res.message_code = ~tog_r ? MSG_BOTH_EMPTY : MSG_BOTH_REFILL;
        mode_nxt         = M_RETRY;
      end else if (ml != LVL_FULL && rl == LVL_FULL) begin
        do_refill = 1'b1;
      end else begin
        do_wstart = 1'b1;
      end
    end

    // refill step
    if (do_refill) begin
      if (item.overflow_seen) begin
        res.main_pump_on = 1'b1;
        res.message_code = MSG_REFILLING;
        tick_nxt         = TICK_W'(1);
        mode_nxt         = (drain_ticks_r <= DRAIN_W'(1)) ? M_HOLD : M_DRAIN;
      end else if (rl == LVL_EMPTY) begin
        res.message_code = MSG_RES_EMPTY;
        mode_nxt         = M_RETRY;
      end else if (ml == LVL_FULL) begin
        res.message_code = MSG_MAIN_FULL;
        mode_nxt         = M_WSTART;
      end else begin
        res.refill_pump_on = 1'b1;
        res.message_code   = MSG_REFILLING;
        mode_nxt           = M_REFILL;
      end
    end

    // watering start, uses the freshly loaded seconds
    if (do_wstart) begin
      res.main_pump_on = 1'b1;
      res.message_code = MSG_WATER_START;
      res.seconds_left = rem_nxt;
      tick_nxt         = '0;
      frame_nxt        = '0;
      mode_nxt         = (rem_nxt == '0) ? M_COMPLETE : M_WATER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= M_IDLE;
      rem_r         <= '0;
      tick_r        <= '0;
      frame_r       <= '0;
      tog_r         <= 1'b0;
      refill_need_r <= 1'b0;
    end else if (step) begin
      mode_r        <= mode_nxt;
      rem_r         <= rem_nxt;
      tick_r        <= tick_nxt;
      frame_r       <= frame_nxt;
      tog_r         <= tog_nxt;
      refill_need_r <= refill_need_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/trws_out_reg.sv -----
// ----------------------------------------------------------------------------
// trws_out_reg
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module trws_out_reg
  import trws_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  trws_out_if.source   out_ch,
  input  wire logic    load,
  input  wire result_t res,
  output logic         can_load
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // room when empty or when the held word leaves this cycle
  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.refill_pump_on = res_r.refill_pump_on;
  assign out_ch.main_pump_on   = res_r.main_pump_on;
  assign out_ch.message_code   = res_r.message_code;
  assign out_ch.seconds_left   = res_r.seconds_left;
  assign out_ch.anim_frame     = res_r.anim_frame;
  assign out_ch.cycle_done     = res_r.cycle_done;

endmodule

`default_nettype wire

// ----- sv/tank_refill_watering_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// tank_refill_watering_sequencer_core
// Pump sequencer: one tick word in, one pump/display result word out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      word
//  in_ch    in   valid/ready    start_request, main_level, reserve_level,
//                               overflow_seen
//  out_ch   out  valid/ready    refill_pump_on, main_pump_on, message_code,
//                               seconds_left, anim_frame, cycle_done
//  cfg_ch   in   valid/ready    index, data (ready always high)
//
//  Path: a word goes through the input register, then the result register,
//  before it leaves on out_ch. One word per cycle sustained while
//  out_ch.ready stays high; the sequencer state update is a single pass
//  of logic between the two registers.
//  Reset: rst_n synchronous, active low; mode idle, counters zero, config
//  registers at their defaults. A stalled result holds the input register,
//  which then drops in_ch.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tank_refill_watering_sequencer_core
  import trws_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = TRWS_TICKS_PER_SECOND
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  trws_in_if.sink    in_ch,
  trws_out_if.source out_ch,
  trws_cfg_if.sink   cfg_ch
);

  logic    in_valid_r;
  item_t   item_r;
  result_t res;
  logic    can_load;
  logic    advance;

  // word moves from input register to result register
  assign advance = in_valid_r && can_load;

  trws_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .take    (advance),
    .valid_r (in_valid_r),
    .item_r  (item_r)
  );

  trws_fsm #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .step   (advance),
    .item   (item_r),
    .res    (res)
  );

  trws_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .out_ch   (out_ch),
    .load     (advance),
    .res      (res),
    .can_load (can_load)
  );

`ifndef SYNTHESIS
  // a processed word always shows up at the output next cycle
  a_adv_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_ch.valid)
    else $error("processed word did not reach result register");

  // pumps never both driven
  a_pumps: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.refill_pump_on && out_ch.main_pump_on))
    else $error("refill and main pump on together");

  // cycle end only from complete, alert or thanks displays
  a_done_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.cycle_done) |->
      (out_ch.message_code == MSG_WATER_DONE || out_ch.message_code == MSG_THANKS ||
       out_ch.message_code == MSG_RES_EMPTY || out_ch.message_code == MSG_RES_REFILL))
    else $error("cycle_done with unexpected message");

  // countdown frame stays in range
  a_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.anim_frame <= FRAME_LAST))
    else $error("animation frame out of range");
`endif

endmodule

`default_nettype wire
